// ----- hdl/per_target_task_queue_manager_top_defines.svh -----
// Assertion macros for the per-target task queue manager.
`ifndef PER_TARGET_TASK_QUEUE_MANAGER_TOP_DEFINES_SVH
`define PER_TARGET_TASK_QUEUE_MANAGER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clk edge outside reset.
`define PTQM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every rising clk edge, reset included.
`define PTQM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PTQM_ASSERT(lbl, prop, msg)
`define PTQM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/ptqm_pkg.sv -----
// Shared types, sizes and codes of the per-target task queue manager.
package ptqm_pkg;

  localparam int MAX_TARGETS = 16;
  localparam int QUEUE_DEPTH = 64;

  // Fixed field widths
  localparam int TID_W    = 4;
  localparam int LEN_W    = 48;
  localparam int PATH_W   = 16;
  localparam int STS_W    = 3;
  localparam int QLIM_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // Targets that can be stored: the id field caps them at 16
  localparam int TGT_N   = (MAX_TARGETS < (1 << TID_W)) ? MAX_TARGETS : (1 << TID_W);
  localparam int IDX_W   = (TGT_N > 1) ? $clog2(TGT_N) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int CAP_W   = (CNT_W > QLIM_W) ? CNT_W : QLIM_W;
  localparam int MEM_DEPTH = TGT_N * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);
  localparam int BUSY_W  = $clog2(TGT_N + 1);
  localparam int STEP_W  = (TID_W > 1) ? $clog2(TID_W) : 1;

  typedef enum logic [1:0] {
    ACT_PUT,
    ACT_GET,
    ACT_FINISH,
    ACT_TICK
  } ptqm_action_t;

  localparam logic [STS_W-1:0] STS_OK        = STS_W'(0);
  localparam logic [STS_W-1:0] STS_FULL      = STS_W'(1);
  localparam logic [STS_W-1:0] STS_UNMANAGED = STS_W'(2);
  localparam logic [STS_W-1:0] STS_EMPTY     = STS_W'(3);
  localparam logic [STS_W-1:0] STS_IDLE      = STS_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OWNER_COUNT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OWNER_INDEX    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PRODUCER_TOTAL = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT    = CFG_IDX_W'(4);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_EXEC
  } ptqm_state_t;

  typedef struct packed {
    logic kind;
    logic [PATH_W-1:0] path;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] length;
  } ptqm_task_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the request beat, start remainder
    logic step;    // one remainder bit
    logic commit;  // apply request, load result register
  } ptqm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } ptqm_sts_t;

endpackage

// ----- hdl/ptqm_ctrl.sv -----
// Request sequencer of the per-target task queue manager.
module ptqm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptqm_pkg::ptqm_sts_t sts,
  output ptqm_pkg::ptqm_cmd_t cmd
);

  ptqm_pkg::ptqm_state_t state, state_next;
  logic [ptqm_pkg::STEP_W-1:0] step_cnt, step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ptqm_pkg::S_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state)
      ptqm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load      = 1'b1;
          step_cnt_next = '0;
          state_next    = ptqm_pkg::S_MOD;
        end
      end
      ptqm_pkg::S_MOD: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == ptqm_pkg::STEP_W'(ptqm_pkg::TID_W - 1)) begin
          state_next = ptqm_pkg::S_EXEC;
        end
      end
      ptqm_pkg::S_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ptqm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptqm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ptqm_dp.sv -----
// Datapath: config registers, owner remainder, queue state, task store, result register.
`include "per_target_task_queue_manager_top_defines.svh"

module ptqm_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ptqm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptqm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [1:0]                           action,
  input  logic [ptqm_pkg::TID_W-1:0]           target_id,
  input  logic                                 task_kind,
  input  logic [ptqm_pkg::LEN_W-1:0]           task_length,
  input  logic [ptqm_pkg::LEN_W-1:0]           task_start,
  input  logic [ptqm_pkg::PATH_W-1:0]          path_handle,
  input  ptqm_pkg::ptqm_cmd_t                  cmd,
  output ptqm_pkg::ptqm_sts_t                  sts,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [ptqm_pkg::STS_W-1:0]           status,
  output logic                                 got_task,
  output logic                                 out_kind,
  output logic [ptqm_pkg::LEN_W-1:0]           out_length,
  output logic [ptqm_pkg::LEN_W-1:0]           out_start,
  output logic [ptqm_pkg::PATH_W-1:0]          out_path_handle,
  output logic                                 all_done
);

  // Config
  logic [4:0] target_count;
  logic [4:0] owner_count;
  logic [3:0] owner_index;
  logic [7:0] producer_total;
  logic [ptqm_pkg::QLIM_W-1:0] queue_limit;

  // Captured request
  ptqm_pkg::ptqm_action_t     req_action;
  logic [ptqm_pkg::TID_W-1:0] req_tgt;
  ptqm_pkg::ptqm_task_t       req_task;

  // Bit-serial remainder of target id by owner count
  logic [4:0]                 div_rem;
  logic [4:0]                 div_rem_next;
  logic [ptqm_pkg::TID_W-1:0] div_bits;
  logic [5:0]                 rem_sh;

  // Queue state
  logic [ptqm_pkg::PTR_W-1:0]  rd_ptr [ptqm_pkg::TGT_N];
  logic [ptqm_pkg::PTR_W-1:0]  wr_ptr [ptqm_pkg::TGT_N];
  logic [ptqm_pkg::CNT_W-1:0]  fill   [ptqm_pkg::TGT_N];
  logic [ptqm_pkg::BUSY_W-1:0] busy_cnt;
  logic [7:0]                  finished;
  logic                        done_sent;

  // Task store
  ptqm_pkg::ptqm_task_t        mem [ptqm_pkg::MEM_DEPTH];
  ptqm_pkg::ptqm_task_t        rd_data;
  logic [ptqm_pkg::ADDR_W-1:0] rd_addr;
  logic [ptqm_pkg::ADDR_W-1:0] wr_addr;
  logic                        mem_we;

  // Request evaluation
  logic [ptqm_pkg::IDX_W-1:0]  idx;
  logic [ptqm_pkg::CNT_W-1:0]  cap;
  logic [ptqm_pkg::CNT_W-1:0]  fill_cur;
  logic                        managed;
  logic                        do_put;
  logic                        do_get;
  logic                        do_fin;
  logic                        do_done;
  logic [ptqm_pkg::STS_W-1:0]  res_status;

  function automatic logic [ptqm_pkg::PTR_W-1:0] advance(
    input logic [ptqm_pkg::PTR_W-1:0] p,
    input logic [ptqm_pkg::CNT_W-1:0] c
  );
    logic [ptqm_pkg::CNT_W-1:0] n;
    n = ptqm_pkg::CNT_W'(p) + 1'b1;
    return (n >= c) ? '0 : n[ptqm_pkg::PTR_W-1:0];
  endfunction

  function automatic logic [ptqm_pkg::ADDR_W-1:0] slot_addr(
    input logic [ptqm_pkg::IDX_W-1:0] i,
    input logic [ptqm_pkg::PTR_W-1:0] p
  );
    return ptqm_pkg::ADDR_W'(i) * ptqm_pkg::ADDR_W'(ptqm_pkg::QUEUE_DEPTH)
           + ptqm_pkg::ADDR_W'(p);
  endfunction

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_count   <= 5'd8;
      owner_count    <= 5'd1;
      owner_index    <= 4'd0;
      producer_total <= 8'd1;
      queue_limit    <= ptqm_pkg::QLIM_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptqm_pkg::CFG_TARGET_COUNT:   target_count   <= cfg_data[4:0];
        ptqm_pkg::CFG_OWNER_COUNT:    owner_count    <= cfg_data[4:0];
        ptqm_pkg::CFG_OWNER_INDEX:    owner_index    <= cfg_data[3:0];
        ptqm_pkg::CFG_PRODUCER_TOTAL: producer_total <= cfg_data[7:0];
        ptqm_pkg::CFG_QUEUE_LIMIT:    queue_limit    <= cfg_data[ptqm_pkg::QLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture and remainder steps
  assign rem_sh = {div_rem, div_bits[ptqm_pkg::TID_W-1]};
  assign div_rem_next = (rem_sh >= {1'b0, owner_count}) ? 5'(rem_sh - {1'b0, owner_count})
                                                        : rem_sh[4:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action      <= ptqm_pkg::ptqm_action_t'(action);
      req_tgt         <= target_id;
      req_task.kind   <= task_kind;
      req_task.path   <= path_handle;
      req_task.start  <= task_start;
      req_task.length <= task_length;
      div_rem         <= '0;
      div_bits        <= target_id;
    end else if (cmd.step) begin
      div_rem  <= div_rem_next;
      div_bits <= div_bits << 1;
    end
  end

  // Evaluation
  assign idx = (5'(req_tgt) < 5'(ptqm_pkg::TGT_N)) ? req_tgt[ptqm_pkg::IDX_W-1:0] : '0;
  assign cap = (ptqm_pkg::CAP_W'(queue_limit) > ptqm_pkg::CAP_W'(ptqm_pkg::QUEUE_DEPTH))
             ? ptqm_pkg::CNT_W'(ptqm_pkg::QUEUE_DEPTH) : ptqm_pkg::CNT_W'(queue_limit);
  assign fill_cur = fill[idx];
  assign managed = (owner_count != 5'd0)
                && ({1'b0, req_tgt} < target_count)
                && (9'(req_tgt) < 9'(ptqm_pkg::MAX_TARGETS))
                && (div_rem == {1'b0, owner_index});

  assign rd_addr = slot_addr(idx, rd_ptr[idx]);
  assign wr_addr = slot_addr(idx, wr_ptr[idx]);

  always_comb begin
    do_put     = 1'b0;
    do_get     = 1'b0;
    do_fin     = 1'b0;
    do_done    = 1'b0;
    res_status = ptqm_pkg::STS_OK;
    unique case (req_action)
      ptqm_pkg::ACT_PUT: begin
        if (!managed) res_status = ptqm_pkg::STS_UNMANAGED;
        else if (fill_cur >= cap) res_status = ptqm_pkg::STS_FULL;
        else do_put = 1'b1;
      end
      ptqm_pkg::ACT_GET: begin
        if (!managed) res_status = ptqm_pkg::STS_UNMANAGED;
        else if (fill_cur == '0) res_status = ptqm_pkg::STS_EMPTY;
        else do_get = 1'b1;
      end
      ptqm_pkg::ACT_FINISH: begin
        do_fin = 1'b1;
      end
      ptqm_pkg::ACT_TICK: begin
        if (!done_sent && finished >= producer_total && busy_cnt == '0) do_done = 1'b1;
        else res_status = ptqm_pkg::STS_IDLE;
      end
      default: res_status = ptqm_pkg::STS_IDLE;
    endcase
  end

  assign mem_we = cmd.commit && do_put;

  // Task store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= req_task;
    rd_data <= mem[rd_addr];
  end

  // Queue state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptqm_pkg::TGT_N; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        fill[i]   <= '0;
      end
      busy_cnt  <= '0;
      finished  <= '0;
      done_sent <= 1'b0;
    end else if (cmd.commit) begin
      if (do_put) begin
        wr_ptr[idx] <= advance(wr_ptr[idx], cap);
        fill[idx]   <= fill_cur + 1'b1;
        if (fill_cur == '0) busy_cnt <= busy_cnt + 1'b1;
      end
      if (do_get) begin
        rd_ptr[idx] <= advance(rd_ptr[idx], cap);
        fill[idx]   <= fill_cur - 1'b1;
        if (fill_cur == ptqm_pkg::CNT_W'(1) && busy_cnt != '0) busy_cnt <= busy_cnt - 1'b1;
      end
      if (do_fin && finished != 8'hFF) finished <= finished + 1'b1;
      if (do_done) done_sent <= 1'b1;
    end
  end

  // Result register
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status          <= res_status;
      got_task        <= do_get;
      out_kind        <= do_get ? rd_data.kind : 1'b0;
      out_length      <= do_get ? rd_data.length : '0;
      out_start       <= do_get ? rd_data.start : '0;
      out_path_handle <= do_get ? rd_data.path : '0;
      all_done        <= do_done;
    end
  end

  `PTQM_ASSERT(a_commit_free, cmd.commit |-> sts.out_free, "result overwritten while held")
  `PTQM_ASSERT(a_busy_bound, busy_cnt <= ptqm_pkg::BUSY_W'(ptqm_pkg::TGT_N), "busy count overflow")
  `PTQM_ASSERT(a_done_beat, out_valid && all_done |-> status == ptqm_pkg::STS_OK && !got_task,
               "done beat malformed")
  `PTQM_ASSERT(a_task_beat, out_valid && got_task |-> status == ptqm_pkg::STS_OK && !all_done,
               "task beat malformed")

endmodule

// ----- hdl/per_target_task_queue_manager_top.sv -----
// Top level of the per-target task queue manager.
// Keeps one ring FIFO of copy tasks per storage target (up to 16 targets, 64 tasks each)
// and answers every request beat with exactly one result beat. A put appends a task to
// the queue of target_id, a get pops its oldest task, a producer-finished beat counts a
// notice (saturating at 255), and an idle tick reports all_done once, after producer_total
// notices have arrived and every queue is empty. Only targets below target_count whose id
// modulo owner_count equals owner_index are served; others return the not-managed status.
// Sequence: each request passes the accept state, a bit-serial remainder unit (one id bit
// per cycle) for the owner check, during which the task store read is also done, and the
// commit state. The commit waits while the result register still holds an untaken beat; a
// new request is taken while a result waits. The task store has no reset; there is no
// clearing pass. Configuration must be written through cfg_we / cfg_index / cfg_data
// while no request is in flight; the block itself does not enforce this.
module per_target_task_queue_manager_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [ptqm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptqm_pkg::CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [ptqm_pkg::TID_W-1:0]      target_id,
  input  logic                            task_kind,
  input  logic [ptqm_pkg::LEN_W-1:0]      task_length,
  input  logic [ptqm_pkg::LEN_W-1:0]      task_start,
  input  logic [ptqm_pkg::PATH_W-1:0]     path_handle,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ptqm_pkg::STS_W-1:0]      status,
  output logic                            got_task,
  output logic                            out_kind,
  output logic [ptqm_pkg::LEN_W-1:0]      out_length,
  output logic [ptqm_pkg::LEN_W-1:0]      out_start,
  output logic [ptqm_pkg::PATH_W-1:0]     out_path_handle,
  output logic                            all_done
);

  ptqm_pkg::ptqm_cmd_t cmd;
  ptqm_pkg::ptqm_sts_t sts;

  // Sequencer: accept, remainder steps, commit
  ptqm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Config, queue state, task store and the result register
  ptqm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .action          (action),
    .target_id       (target_id),
    .task_kind       (task_kind),
    .task_length     (task_length),
    .task_start      (task_start),
    .path_handle     (path_handle),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .status          (status),
    .got_task        (got_task),
    .out_kind        (out_kind),
    .out_length      (out_length),
    .out_start       (out_start),
    .out_path_handle (out_path_handle),
    .all_done        (all_done)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the per-target task queue manager: random requests vs a queue mirror.
`timescale 1ns / 100ps

module tb_top;

  // Run limits: the slowest legal beat costs a send gap, the block's accept, remainder and
  // commit states and a receiver hold; about 1750 beats are sent in all.
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned DRAIN_WAIT  = 12;   // extra wait after the last result is taken
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned PHASE_BEATS = 200;

  // One request beat as the sender sees it.
  typedef struct {
    ptqm_pkg::ptqm_action_t      act;
    logic [ptqm_pkg::TID_W-1:0]  tgt;
    logic                        kind;
    logic [ptqm_pkg::LEN_W-1:0]  length;
    logic [ptqm_pkg::LEN_W-1:0]  start;
    logic [ptqm_pkg::PATH_W-1:0] path;
  } req_t;

  // One result beat, field for field.
  typedef struct {
    logic [ptqm_pkg::STS_W-1:0]  status;
    logic                        got;
    logic                        kind;
    logic [ptqm_pkg::LEN_W-1:0]  length;
    logic [ptqm_pkg::LEN_W-1:0]  start;
    logic [ptqm_pkg::PATH_W-1:0] path;
    logic                        done;
  } reply_t;

  // Mirror of the per-target ring queues plus the done bookkeeping. Each accepted
  // request is applied here and its reply is queued; result beats are popped in order.
  class queue_mirror;
    ptqm_pkg::ptqm_task_t store [ptqm_pkg::TGT_N][ptqm_pkg::QUEUE_DEPTH];
    int unsigned rd_ptr [ptqm_pkg::TGT_N] = '{default: 0};
    int unsigned wr_ptr [ptqm_pkg::TGT_N] = '{default: 0};
    int unsigned fill [ptqm_pkg::TGT_N]   = '{default: 0};
    int unsigned busy_queues = 0;
    int unsigned finish_seen = 0;
    bit          done_flag = 1'b0;

    int unsigned tgt_count  = 8;
    int unsigned own_count  = 1;
    int unsigned own_index  = 0;
    int unsigned prod_total = 1;
    int unsigned q_limit    = 64;

    reply_t      pending_replies [$];
    int unsigned errors = 0;

    function void set_reg(logic [ptqm_pkg::CFG_IDX_W-1:0] idx,
                          logic [ptqm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ptqm_pkg::CFG_TARGET_COUNT:   tgt_count  = data & 8'h1F;
        ptqm_pkg::CFG_OWNER_COUNT:    own_count  = data & 8'h1F;
        ptqm_pkg::CFG_OWNER_INDEX:    own_index  = data & 8'h0F;
        ptqm_pkg::CFG_PRODUCER_TOTAL: prod_total = data;
        ptqm_pkg::CFG_QUEUE_LIMIT:    q_limit    = data & 8'h7F;
        default: ;
      endcase
    endfunction

    function bit serves(int unsigned t);
      if (t >= ptqm_pkg::TGT_N || t >= tgt_count || own_count == 0) return 1'b0;
      return (t % own_count) == own_index;
    endfunction

    function int unsigned capacity();
      return (q_limit > ptqm_pkg::QUEUE_DEPTH) ? ptqm_pkg::QUEUE_DEPTH : q_limit;
    endfunction

    function int unsigned step_ptr(int unsigned p, int unsigned lim);
      return (p + 1 >= lim) ? 0 : p + 1;
    endfunction

    function void absorb_request(req_t r);
      reply_t      e;
      int unsigned t;
      int unsigned slot;
      int unsigned lim;
      e = '{default: '0};
      t = r.tgt;
      lim = capacity();
      e.status = ptqm_pkg::STS_OK;
      case (r.act)
        ptqm_pkg::ACT_PUT: begin
          if (!serves(t)) begin
            e.status = ptqm_pkg::STS_UNMANAGED;
          end else if (fill[t] >= lim) begin
            e.status = ptqm_pkg::STS_FULL;
          end else begin
            slot = wr_ptr[t] % ptqm_pkg::QUEUE_DEPTH;
            store[t][slot] = '{kind: r.kind, path: r.path, start: r.start, length: r.length};
            wr_ptr[t] = step_ptr(slot, lim);
            if (fill[t] == 0) busy_queues++;
            fill[t]++;
          end
        end
        ptqm_pkg::ACT_GET: begin
          if (!serves(t)) begin
            e.status = ptqm_pkg::STS_UNMANAGED;
          end else if (fill[t] == 0) begin
            e.status = ptqm_pkg::STS_EMPTY;
          end else begin
            slot = rd_ptr[t] % ptqm_pkg::QUEUE_DEPTH;
            e.got    = 1'b1;
            e.kind   = store[t][slot].kind;
            e.length = store[t][slot].length;
            e.start  = store[t][slot].start;
            e.path   = store[t][slot].path;
            rd_ptr[t] = step_ptr(slot, lim);
            fill[t]--;
            if (fill[t] == 0 && busy_queues > 0) busy_queues--;
          end
        end
        ptqm_pkg::ACT_FINISH: begin
          if (finish_seen < 255) finish_seen++;
        end
        default: begin
          if (!done_flag && finish_seen >= prod_total && busy_queues == 0) begin
            done_flag = 1'b1;
            e.done = 1'b1;
          end else begin
            e.status = ptqm_pkg::STS_IDLE;
          end
        end
      endcase
      pending_replies.push_back(e);
    endfunction

    function void check_reply(reply_t seen);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("[%0t] result beat with nothing outstanding, status %0d", $time, seen.status);
        return;
      end
      want = pending_replies.pop_front();
      if (seen.status !== want.status || seen.got !== want.got || seen.kind !== want.kind ||
          seen.length !== want.length || seen.start !== want.start ||
          seen.path !== want.path || seen.done !== want.done) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("[%0t] mismatch want sts=%0d got=%b kind=%b len=%h start=%h path=%h done=%b",
                   $time, want.status, want.got, want.kind, want.length, want.start,
                   want.path, want.done, "\n          saw  sts=%0d got=%b kind=%b len=%h ",
                   seen.status, seen.got, seen.kind, seen.length,
                   "start=%h path=%h done=%b", seen.start, seen.path, seen.done);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_we = 1'b0;
  logic [ptqm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ptqm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  action = '0;
  logic [ptqm_pkg::TID_W-1:0]  target_id = '0;
  logic                        task_kind = 1'b0;
  logic [ptqm_pkg::LEN_W-1:0]  task_length = '0;
  logic [ptqm_pkg::LEN_W-1:0]  task_start = '0;
  logic [ptqm_pkg::PATH_W-1:0] path_handle = '0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [ptqm_pkg::STS_W-1:0]  status;
  logic                        got_task;
  logic                        out_kind;
  logic [ptqm_pkg::LEN_W-1:0]  out_length;
  logic [ptqm_pkg::LEN_W-1:0]  out_start;
  logic [ptqm_pkg::PATH_W-1:0] out_path_handle;
  logic                        all_done;

  always #6 clk = ~clk;

  per_target_task_queue_manager_top dut (
    .clk, .rst,
    .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .action, .target_id, .task_kind,
    .task_length, .task_start, .path_handle,
    .out_valid, .out_stall, .status, .got_task, .out_kind,
    .out_length, .out_start, .out_path_handle, .all_done
  );

  queue_mirror board = new;

  // When set, neither side inserts gaps; redrawn every 40 beats (set with one chance in four)
  // so that back-to-back stretches alternate with randomly gapped ones.
  bit          no_idle = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;

  // ---------------------------------------------------------------------------
  // Result side: take a beat, check it, then hold stall for a drawn number of cycles.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int unsigned hold;
    reply_t      seen;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen.status = status;
        seen.got    = got_task;
        seen.kind   = out_kind;
        seen.length = out_length;
        seen.start  = out_start;
        seen.path   = out_path_handle;
        seen.done   = all_done;
        board.check_reply(seen);
        hold = no_idle ? 0 : $urandom_range(0, 7);
        stall_left <= hold;
        out_stall  <= (hold != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= (stall_left > 1);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // 48-bit field value, with the all-zero and all-one extremes mixed in.
  function automatic logic [ptqm_pkg::LEN_W-1:0] rand_span();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return w[ptqm_pkg::LEN_W-1:0];
    endcase
  endfunction

  function automatic req_t make_req(ptqm_pkg::ptqm_action_t a, int unsigned t);
    req_t r;
    r.act    = a;
    r.tgt    = ptqm_pkg::TID_W'(t);
    r.kind   = 1'($urandom_range(0, 1));
    r.length = rand_span();
    r.start  = rand_span();
    case ($urandom_range(0, 9))
      0: r.path = '0;
      1: r.path = '1;
      default: r.path = ptqm_pkg::PATH_W'($urandom);
    endcase
    return r;
  endfunction

  // Drive one request beat and note it in the mirror once it is accepted.
  // Valid stays high across a zero gap so it is never dropped and raised in one step.
  task automatic send(input req_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= r.act;
    target_id   <= r.tgt;
    task_kind   <= r.kind;
    task_length <= r.length;
    task_start  <= r.start;
    path_handle <= r.path;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.absorb_request(r);
    beats_sent++;
    if (beats_sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // Stop requesting and wait until every predicted result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Config writes go back to back; the enable stays high between them.
  task automatic write_reg(input logic [ptqm_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [7:0] tc, oc, oi, pt, ql);
    write_reg(ptqm_pkg::CFG_TARGET_COUNT, tc);
    write_reg(ptqm_pkg::CFG_OWNER_COUNT, oc);
    write_reg(ptqm_pkg::CFG_OWNER_INDEX, oi);
    write_reg(ptqm_pkg::CFG_PRODUCER_TOTAL, pt);
    write_reg(ptqm_pkg::CFG_QUEUE_LIMIT, ql);
    cfg_we <= 1'b0;
  endtask

  // Hand-picked beats: unmanaged targets, empty and full queues, field extremes,
  // the done tick and requests served after it.
  task automatic directed_checks();
    req_t r;
    // reset settings: 8 targets, one owner, one producer, 64 deep
    send(make_req(ptqm_pkg::ACT_TICK, 0));    // nothing finished yet
    send(make_req(ptqm_pkg::ACT_GET, 0));     // empty queue
    send(make_req(ptqm_pkg::ACT_PUT, 15));    // beyond target count
    send(make_req(ptqm_pkg::ACT_GET, 8));
    r = make_req(ptqm_pkg::ACT_PUT, 0);
    r.kind = 1'b1; r.length = '1; r.start = '1; r.path = '1;
    send(r);
    r = make_req(ptqm_pkg::ACT_PUT, 0);
    r.kind = 1'b0; r.length = '0; r.start = '0; r.path = '0;
    send(r);
    r = make_req(ptqm_pkg::ACT_PUT, 7);
    r.kind = 1'b1; r.length = 48'h5555_5555_5555; r.start = 48'hAAAA_AAAA_AAAA;
    r.path = 16'h5A5A;
    send(r);
    send(make_req(ptqm_pkg::ACT_FINISH, 0));
    send(make_req(ptqm_pkg::ACT_TICK, 0));    // producers done but queues busy
    send(make_req(ptqm_pkg::ACT_GET, 0));
    send(make_req(ptqm_pkg::ACT_GET, 0));
    send(make_req(ptqm_pkg::ACT_GET, 0));     // drained
    send(make_req(ptqm_pkg::ACT_GET, 7));
    send(make_req(ptqm_pkg::ACT_TICK, 0));    // the one done beat
    send(make_req(ptqm_pkg::ACT_TICK, 0));    // never repeated
    send(make_req(ptqm_pkg::ACT_PUT, 3));     // still served after done
    send(make_req(ptqm_pkg::ACT_GET, 3));
    settle();
    // two-deep queues to hit the full status
    apply_settings(8'd8, 8'd1, 8'd0, 8'd1, 8'd2);
    repeat (3) send(make_req(ptqm_pkg::ACT_PUT, 1));
    repeat (3) send(make_req(ptqm_pkg::ACT_GET, 1));
    settle();
  endtask

  // One random phase: new settings, one queue filled to the brim, a random mix that
  // mostly hits served targets, then every queue drained so the next settings start clean.
  task automatic run_phase(input logic [7:0] tc, oc, oi, pt, ql, input int unsigned finish_pct);
    int unsigned serving [$];
    int unsigned t;
    int unsigned roll;
    ptqm_pkg::ptqm_action_t a;
    apply_settings(tc, oc, oi, pt, ql);
    for (int i = 0; i < ptqm_pkg::TGT_N; i++)
      if (board.serves(i)) serving.push_back(i);

    if (serving.size() != 0) begin
      t = serving[$urandom_range(0, serving.size() - 1)];
      while (board.fill[t] < board.capacity()) send(make_req(ptqm_pkg::ACT_PUT, t));
      send(make_req(ptqm_pkg::ACT_PUT, t));   // rejected as full
    end

    repeat (PHASE_BEATS) begin
      if (serving.size() != 0 && $urandom_range(0, 9) < 8)
        t = serving[$urandom_range(0, serving.size() - 1)];
      else
        t = $urandom_range(0, ptqm_pkg::TGT_N - 1);
      roll = $urandom_range(0, 99);
      if (roll < finish_pct)
        a = ptqm_pkg::ACT_FINISH;
      else if (roll < finish_pct + 5)
        a = ptqm_pkg::ACT_TICK;
      else if ($urandom_range(0, 99) < 55)
        a = ptqm_pkg::ACT_PUT;
      else
        a = ptqm_pkg::ACT_GET;
      send(make_req(a, t));
    end

    // queues holding tasks are all served under the current settings
    for (int i = 0; i < ptqm_pkg::TGT_N; i++)
      while (board.serves(i) && board.fill[i] != 0) send(make_req(ptqm_pkg::ACT_GET, i));
    send(make_req(ptqm_pkg::ACT_TICK, 0));
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_checks();

    //         targets owners index  producers limit  finish%
    run_phase(8'd16,   8'd1,  8'd0,  8'd255,   8'd64,  10);
    run_phase(8'd1,    8'd16, 8'd0,  8'd1,     8'd1,   10);
    run_phase(8'd16,   8'd3,  8'd2,  8'd5,     8'd4,   40);
    run_phase(8'd16,   8'd16, 8'd15, 8'd0,     8'd127, 10);  // limit above depth
    run_phase(8'd11,   8'd0,  8'd0,  8'd10,    8'd3,   40);  // no owners: nothing served
    run_phase(8'd16,   8'd2,  8'd1,  8'd2,     8'd0,   10);  // zero limit: always full
    run_phase(8'd31,   8'd4,  8'd3,  8'd3,     8'd8,   40);  // finish count saturates

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
